// File: rtl/core/dd_odom_pkg.sv
package dd_odom_pkg;

	localparam int unsigned ADDR_W = 4;

	localparam logic [ADDR_W-1:0] ADDR_RADIUS    = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_BASE      = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 4'h8;

	localparam logic [15:0] RADIUS_RST    = 16'd2294;
	localparam logic [17:0] BASE_RST      = 18'd17170;
	localparam logic [15:0] THRESHOLD_RST = 16'd66;

	localparam logic signed [35:0] TWO_PI_Q16  = 36'sd411775;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] GAIN_Q30    = 36'sd652032875;
	localparam logic signed [63:0] R_LIMIT     = 64'sd2147483647;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] v;
		case (i)
			5'd0: v = 36'sd843314857;
			5'd1: v = 36'sd497837829;
			5'd2: v = 36'sd263043837;
			5'd3: v = 36'sd133525159;
			5'd4: v = 36'sd67021687;
			5'd5: v = 36'sd33543516;
			5'd6: v = 36'sd16775851;
			5'd7: v = 36'sd8388437;
			5'd8: v = 36'sd4194283;
			5'd9: v = 36'sd2097149;
			default: v = 36'sd1 <<< (5'd30 - i);
		endcase
		return v;
	endfunction

	typedef struct packed {
		logic load;      // capture the item and start the difference step
		logic scale;     // multiply angle differences by the radius
		logic sums;      // form sum and difference
		logic dth_start; // start dtheta division
		logic wrap;      // wrap the heading
		logic cor_start; // start CORDIC on selected angle
		logic cor_sel;   // 0: old heading, 1: new heading
		logic save0;     // store first CORDIC result
		logic r_start;   // start radius division
		logic mul_a;     // first product
		logic mul_b;     // second product
		logic commit;    // update the pose
		logic skip;      // first item: record angles only
	} dd_cmd_t;

	typedef struct packed {
		logic div_done;
		logic cor_done;
		logic straight;
	} dd_sts_t;

endpackage

// File: rtl/core/dd_odom_div.sv
module dd_odom_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic               done,
	output logic signed [63:0] quo
);
	import dd_odom_pkg::*;

	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [63:0] r_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {r_q, n_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[63] ? 64'(-num) : num;
			d_q   <= den[63] ? 64'(-den) : den;
			neg_q <= num[63] ^ den[63];
			r_q   <= '0;
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], n_q[63]};
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? 64'(-n_q) : n_q;
endmodule

// File: rtl/core/dd_odom_cordic.sv
module dd_odom_cordic #(
	parameter int unsigned CORDIC_STEPS = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [18:0]        angle,
	output logic               done,
	output logic signed [35:0] cos_o,
	output logic signed [35:0] sin_o
);
	import dd_odom_pkg::*;

	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [35:0] a_q;
	logic               neg_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic signed [35:0] a0;
	logic signed [35:0] a1;
	logic               neg0;
	logic signed [35:0] xs;
	logic signed [35:0] ys;

	always_comb begin
		a0 = 36'(signed'({3'b0, angle, 14'b0}));
		if (a0 > PI_Q30) begin
			a0 = a0 - TWO_PI_Q30;
		end
		neg0 = 1'b0;
		a1 = a0;
		if (a0 > HALF_PI_Q30) begin
			a1 = a0 - PI_Q30;
			neg0 = 1'b1;
		end else if (a0 < -HALF_PI_Q30) begin
			a1 = a0 + PI_Q30;
			neg0 = 1'b1;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= GAIN_Q30;
			y_q   <= '0;
			a_q   <= a1;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (!a_q[35]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				a_q <= a_q - atan_q30(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				a_q <= a_q + atan_q30(i_q);
			end
		end
	end

	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;
endmodule

// File: rtl/core/dd_odom_datapath.sv
module dd_odom_datapath #(
	parameter int unsigned CORDIC_STEPS = 18
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dd_odom_pkg::dd_cmd_t     cmd,
	output dd_odom_pkg::dd_sts_t     sts,
	input  logic [31:0]              encoder_left,
	input  logic [31:0]              encoder_right,
	input  logic [15:0]              wheel_radius,
	input  logic [17:0]              wheel_base,
	input  logic [15:0]              straight_threshold,
	output logic signed [31:0]       pos_x,
	output logic signed [31:0]       pos_y,
	output logic [18:0]              heading
);
	import dd_odom_pkg::*;

	logic [31:0]        prev_l_q;
	logic [31:0]        prev_r_q;
	logic signed [31:0] wl_q;
	logic signed [31:0] wr_q;
	logic signed [48:0] dl_q;
	logic signed [48:0] dr_q;
	logic signed [49:0] sum_q;
	logic signed [49:0] diff_q;
	logic [18:0]        base_q;
	logic signed [63:0] dth_q;
	logic [18:0]        nh_q;
	logic signed [35:0] c0_q;
	logic signed [35:0] s0_q;
	logic signed [63:0] r_q;
	logic signed [63:0] pa_q;
	logic signed [63:0] pb_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic [18:0]        hd_q;
	logic               use_dth_q;

	logic               div_start;
	logic signed [63:0] div_num;
	logic signed [63:0] div_den;
	logic               div_done;
	logic signed [63:0] div_quo;
	logic               cor_done;
	logic signed [35:0] cos_w;
	logic signed [35:0] sin_w;
	logic signed [63:0] nh_sum;
	logic signed [63:0] nh_mod;
	logic signed [63:0] r_sat;
	logic signed [63:0] fac_a;
	logic signed [63:0] fac_b;
	logic signed [63:0] mul_a;
	logic signed [63:0] dx;
	logic signed [63:0] dy;
	logic signed [49:0] mag;
	logic               straight;

	assign div_start = cmd.dth_start | cmd.r_start;
	assign div_num   = cmd.dth_start ? 64'(diff_q) <<< 16 : 64'($signed({1'b0, base_q})) * 64'(sum_q);
	assign div_den   = cmd.dth_start ? 64'($signed({1'b0, base_q})) : 64'(diff_q) <<< 1;

	dd_odom_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	dd_odom_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.cor_start),
		.angle (cmd.cor_sel ? nh_q : hd_q),
		.done  (cor_done),
		.cos_o (cos_w),
		.sin_o (sin_w)
	);

	// The remainder lies inside +-2*pi in Q16.16, so one wrap suffices after it.
	assign nh_sum = 64'($signed({1'b0, hd_q})) + dth_q;
	assign nh_mod = nh_sum % 64'(TWO_PI_Q16);

	assign mag      = diff_q[49] ? -diff_q : diff_q;
	assign straight = (mag < 50'($signed({1'b0, straight_threshold}))) || (diff_q == 0);

	assign r_sat = (div_quo > R_LIMIT) ? R_LIMIT : (div_quo < -R_LIMIT) ? -R_LIMIT : div_quo;

	always_comb begin
		if (straight) begin
			fac_a = 64'(sum_q >>> 1);
			fac_b = cmd.mul_a ? 64'(c0_q) : 64'(s0_q);
		end else begin
			fac_a = r_q;
			fac_b = cmd.mul_a ? 64'(sin_w - s0_q) : 64'(c0_q - cos_w);
		end
	end
	assign mul_a = fac_a * fac_b;

	assign dx = pa_q >>> 30;
	assign dy = pb_q >>> 30;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -65'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			px_q     <= '0;
			py_q     <= '0;
			hd_q     <= '0;
		end else begin
			if (cmd.skip) begin
				prev_l_q <= encoder_left;
				prev_r_q <= encoder_right;
			end
			if (cmd.load) begin
				prev_l_q <= encoder_left;
				prev_r_q <= encoder_right;
			end
			if (cmd.commit) begin
				px_q <= sat_add(px_q, dx);
				py_q <= sat_add(py_q, dy);
				hd_q <= nh_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wl_q   <= $signed(encoder_left - prev_l_q);
			wr_q   <= $signed(encoder_right - prev_r_q);
			base_q <= (wheel_base == '0) ? 19'd1 : {1'b0, wheel_base};
		end
		if (cmd.scale) begin
			dl_q <= 49'((64'(wl_q) * 64'($signed({1'b0, wheel_radius}))) >>> 16);
			dr_q <= 49'((64'(wr_q) * 64'($signed({1'b0, wheel_radius}))) >>> 16);
		end
		if (cmd.sums) begin
			sum_q  <= 50'(dl_q) + 50'(dr_q);
			diff_q <= 50'(dr_q) - 50'(dl_q);
		end
		use_dth_q <= cmd.dth_start ? 1'b1 : (cmd.r_start ? 1'b0 : use_dth_q);
		if (div_done && use_dth_q) begin
			dth_q <= div_quo;
		end
		if (div_done && !use_dth_q) begin
			r_q <= r_sat;
		end
		if (cmd.wrap) begin
			nh_q <= 19'(nh_mod < 0 ? nh_mod + 64'(TWO_PI_Q16) : nh_mod);
		end
		if (cmd.save0) begin
			c0_q <= cos_w;
			s0_q <= sin_w;
		end
		if (cmd.mul_a) begin
			pa_q <= mul_a;
		end
		if (cmd.mul_b) begin
			pb_q <= mul_a;
		end
	end

	assign sts.div_done = div_done;
	assign sts.cor_done = cor_done;
	assign sts.straight = straight;

	assign pos_x   = px_q;
	assign pos_y   = py_q;
	assign heading = hd_q;
endmodule

// File: rtl/core/dd_odom_ctrl.sv
module dd_odom_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  dd_odom_pkg::dd_sts_t sts,
	output dd_odom_pkg::dd_cmd_t cmd
);
	import dd_odom_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_SCALE  = 13'b0000000000010,
		ST_SUMS   = 13'b0000000000100,
		ST_DTH    = 13'b0000000001000,
		ST_DTHW   = 13'b0000000010000,
		ST_WRAP   = 13'b0000000100000,
		ST_COR0   = 13'b0000001000000,
		ST_DECIDE = 13'b0000010000000,
		ST_RDIV   = 13'b0000100000000,
		ST_COR1   = 13'b0001000000000,
		ST_MULA   = 13'b0010000000000,
		ST_MULB   = 13'b0100000000000,
		ST_COMMIT = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic   first_q;
	logic   out_valid_q;
	logic   accept;
	logic   cor1_started_q;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.skip      = accept && first_q;
		cmd.load      = accept && !first_q;
		cmd.scale     = (state_q == ST_SCALE);
		cmd.sums      = (state_q == ST_SUMS);
		cmd.dth_start = (state_q == ST_DTH);
		cmd.wrap      = (state_q == ST_WRAP);
		cmd.cor_start = (state_q == ST_WRAP) || ((state_q == ST_RDIV) && sts.div_done);
		cmd.cor_sel   = (state_q == ST_RDIV) || (state_q == ST_COR1);
		cmd.save0     = (state_q == ST_COR0) && sts.cor_done;
		cmd.r_start   = (state_q == ST_DECIDE) && !sts.straight;
		cmd.mul_a     = (state_q == ST_MULA);
		cmd.mul_b     = (state_q == ST_MULB);
		cmd.commit    = (state_q == ST_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			first_q        <= 1'b1;
			out_valid_q    <= 1'b0;
			cor1_started_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			cor1_started_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (first_q) begin
							first_q     <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_SCALE;
						end
					end
				end
				ST_SCALE:  state_q <= ST_SUMS;
				ST_SUMS:   state_q <= ST_DTH;
				ST_DTH:    state_q <= ST_DTHW;
				ST_DTHW: begin
					if (sts.div_done) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP:   state_q <= ST_COR0;
				ST_COR0: begin
					if (sts.cor_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: state_q <= sts.straight ? ST_MULA : ST_RDIV;
				ST_RDIV: begin
					if (sts.div_done) begin
						state_q <= ST_COR1;
					end
				end
				ST_COR1: begin
					if (sts.cor_done) begin
						state_q <= ST_MULA;
					end
				end
				ST_MULA:   state_q <= ST_MULB;
				ST_MULB:   state_q <= ST_COMMIT;
				ST_COMMIT: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/differential_drive_odometry.sv
// Channel  | Handshake                | Payload
// input    | in_valid / in_ready      | encoder_left, encoder_right
// output   | out_valid / out_ready    | pos_x, pos_y, heading
// config   | APB psel/penable/pwrite  | paddr, pwdata, prdata
//
// The first item is answered in the cycle after it is accepted. Later items
// use the shared restoring divider and the CORDIC once each on a straight step
// and twice each otherwise; no new item is accepted while one is in work.
// Reset clears the pose and the previous angles and arms the first-item rule.
// A waiting result blocks the next transfer only until it is taken.
module differential_drive_odometry #(
	parameter int unsigned CORDIC_STEPS = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [31:0]              encoder_left,
	input  logic signed [31:0]              encoder_right,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              pos_x,
	output logic signed [31:0]              pos_y,
	output logic [18:0]                     heading,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dd_odom_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import dd_odom_pkg::*;

	logic [15:0] radius_q;
	logic [17:0] base_q;
	logic [15:0] thresh_q;
	dd_cmd_t     cmd;
	dd_sts_t     sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			base_q   <= BASE_RST;
			thresh_q <= THRESHOLD_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_RADIUS:    radius_q <= pwdata[15:0];
				ADDR_BASE:      base_q   <= pwdata[17:0];
				ADDR_THRESHOLD: thresh_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_RADIUS:    prdata = {16'b0, radius_q};
			ADDR_BASE:      prdata = {14'b0, base_q};
			ADDR_THRESHOLD: prdata = {16'b0, thresh_q};
			default:        prdata = '0;
		endcase
	end

	dd_odom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dd_odom_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.encoder_left      (encoder_left),
		.encoder_right     (encoder_right),
		.wheel_radius      (radius_q),
		.wheel_base        (base_q),
		.straight_threshold(thresh_q),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.heading           (heading)
	);
endmodule

// File: rtl/core/dd_odom_checker.sv
module dd_odom_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [18:0] heading,
	input logic        pready
);
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading < 19'd411775) else $error("heading out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready || out_valid) else $error("overlapping items");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind differential_drive_odometry dd_odom_checker u_dd_odom_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.heading  (heading),
	.pready   (pready)
);
